### hdl/aavl_pkg.sv
// shared types, constants and the arctangent table for the aim and launch core
// no dependencies

package aavl_pkg;

	localparam int FRAC_BITS         = 8;
	localparam int ANG_Q             = 16;
	localparam int TRIG_Q            = 30;
	localparam int VEC_PRESCALE      = 16;
	localparam int CORDIC_STEPS_DEF  = 16;
	localparam int GAIN_INV          = 652032874;
	localparam int VEL_LIMIT         = 65535;
	localparam int ANGLE_LIM         = 90 * (1 << FRAC_BITS);
	localparam int ANGLE_RESET       = 40 * (1 << FRAC_BITS);

	localparam int XY_W  = 34;   // cordic x/y datapath
	localparam int Z_W   = 26;   // cordic angle accumulator, degrees q16
	localparam int PW    = 50;   // product accumulators
	localparam int SPD_W = 16;
	localparam int LEN_W = 8;
	localparam int MCW   = $clog2(SPD_W);

	localparam logic OP_AIM   = 1'b0;
	localparam logic OP_SHOOT = 1'b1;

	localparam logic [1:0] REG_ORIGIN_X = 2'd0;
	localparam logic [1:0] REG_ORIGIN_Y = 2'd1;
	localparam logic [1:0] REG_BARREL   = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CORD,
		ST_MUL,
		ST_FIN
	} aavl_state_t;

	typedef struct packed {
		logic load;
		logic rot;
	} cordic_ctrl_t;

	typedef struct packed {
		logic run;
		logic last;
	} cordic_stat_t;

	// atan(2^-i) in degrees, q16
	function automatic logic [21:0] atan_q16(input logic [4:0] i);
		logic [21:0] r;
		begin
			case (i)
				5'd0:  r = 22'd2949120;
				5'd1:  r = 22'd1740967;
				5'd2:  r = 22'd919879;
				5'd3:  r = 22'd466945;
				5'd4:  r = 22'd234379;
				5'd5:  r = 22'd117304;
				5'd6:  r = 22'd58666;
				5'd7:  r = 22'd29335;
				5'd8:  r = 22'd14668;
				5'd9:  r = 22'd7334;
				5'd10: r = 22'd3667;
				5'd11: r = 22'd1833;
				5'd12: r = 22'd917;
				5'd13: r = 22'd458;
				5'd14: r = 22'd229;
				5'd15: r = 22'd115;
				5'd16: r = 22'd57;
				5'd17: r = 22'd29;
				5'd18: r = 22'd14;
				5'd19: r = 22'd7;
				5'd20: r = 22'd4;
				5'd21: r = 22'd2;
				5'd22: r = 22'd1;
				default: r = 22'd0;
			endcase
			return r;
		end
	endfunction

endpackage

### hdl/aavl_cordic.sv
// iterative cordic, one micro-rotation per cycle, vectoring or rotation mode
// depends on aavl_pkg

module aavl_cordic import aavl_pkg::*; #(
	parameter int STEPS = CORDIC_STEPS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cordic_ctrl_t           ctrl,
	input  logic signed [XY_W-1:0] x_in,
	input  logic signed [XY_W-1:0] y_in,
	input  logic signed [Z_W-1:0]  z_in,
	output logic signed [XY_W-1:0] x_out,
	output logic signed [XY_W-1:0] y_out,
	output logic signed [Z_W-1:0]  z_out,
	output cordic_stat_t           stat
);

	localparam int CW = $clog2(STEPS);

	logic signed [XY_W-1:0] x_q, y_q, xs, ys;
	logic signed [Z_W-1:0]  z_q, at;
	logic [CW-1:0]          cnt_q;
	logic                   run_q, rot_q, neg;

	always_comb begin
		xs  = x_q >>> cnt_q;
		ys  = y_q >>> cnt_q;
		at  = $signed({{(Z_W-22){1'b0}}, atan_q16(5'(cnt_q))});
		// rotate clockwise when driving y or z towards zero from the other side
		neg = rot_q ? z_q[Z_W-1] : (!y_q[XY_W-1] && (y_q != '0));
		stat.run  = run_q;
		stat.last = run_q && (cnt_q == CW'(STEPS - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (ctrl.load) begin
			run_q <= 1'b1;
			cnt_q <= '0;
		end else if (run_q) begin
			if (stat.last) run_q <= 1'b0;
			cnt_q <= cnt_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			x_q   <= x_in;
			y_q   <= y_in;
			z_q   <= z_in;
			rot_q <= ctrl.rot;
		end else if (run_q) begin
			if (neg) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end
		end
	end

	assign x_out = x_q;
	assign y_out = y_q;
	assign z_out = z_q;

endmodule

### hdl/aim_angle_and_launch_vector_core.sv
// aim angle and launch vector core: top level with fsm, serial multipliers, outputs
// depends on aavl_pkg and aavl_cordic
// one item at a time; the cordic loop (one step a cycle) runs, then a shoot waits for the
// last micro-rotation to land and runs the bit-serial multiply (one speed bit a cycle,
// 16 bits); the receiver cannot stall; done is high for one cycle per item, and the
// next item may be accepted in that cycle
// asynchronous active-low reset restores the config, state, counter, barrel and done registers

module aim_angle_and_launch_vector_core import aavl_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               opcode,
	input  logic [11:0]        target_x,
	input  logic [11:0]        target_y,
	input  logic [15:0]        speed,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [11:0]        cfg_data,
	output logic               done,
	output logic signed [15:0] angle_out,
	output logic signed [21:0] muzzle_x,
	output logic signed [21:0] muzzle_y,
	output logic signed [16:0] vel_x,
	output logic signed [16:0] vel_y,
	output logic               degenerate
);

	// configuration registers
	logic [11:0]        ox_q, oy_q;
	logic [7:0]         len_q;
	logic signed [15:0] barrel_q;

	// per-item capture
	logic               op_q, degen_q, vert_q, horz_q, dypos_q;
	logic [SPD_W-1:0]   mspd_q;
	logic [LEN_W-1:0]   mlen_q;
	logic [MCW-1:0]     mcnt_q;

	aavl_state_t state_q, state_d;
	logic        accept, mul_load, mul_last;

	// cordic hookup
	cordic_ctrl_t           cctrl;
	cordic_stat_t           cstat;
	logic signed [12:0]     dx, dy, ax, ay;
	logic signed [XY_W-1:0] cx_in, cy_in, cx, cy;
	logic signed [Z_W-1:0]  cz_in, cz;

	// serial multiplier
	logic signed [PW-1:0] mc_c_q, mc_s_q;
	logic signed [PW-1:0] acc_lc_q, acc_ls_q, acc_vc_q, acc_vs_q;

	// finishing arithmetic
	logic signed [Z_W-1:0] zr;
	logic signed [15:0]    ang_new;
	logic signed [PW-1:0]  lc_r, ls_r, vc_r, vs_r, mx_f, my_f, vx_f, vy_f;

	// output registers
	logic               done_q, degen_out_q;
	logic signed [15:0] angle_q;
	logic signed [21:0] mx_q, my_q;
	logic signed [16:0] vx_q, vy_q;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	// configuration beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ox_q  <= 12'd0;
			oy_q  <= 12'd600;
			len_q <= 8'd60;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ORIGIN_X: ox_q  <= cfg_data;
				REG_ORIGIN_Y: oy_q  <= cfg_data;
				REG_BARREL:   len_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// aim vector, y flipped so that up is positive
	assign dx = $signed({1'b0, target_x}) - $signed({1'b0, ox_q});
	assign dy = $signed({1'b0, oy_q}) - $signed({1'b0, target_y});
	// fold the left half-plane onto the right (single-argument atan)
	assign ax = dx[12] ? -dx : dx;
	assign ay = dx[12] ? -dy : dy;

	always_comb begin
		cctrl.load = accept;
		cctrl.rot  = opcode;
		if (opcode == OP_SHOOT) begin
			cx_in = XY_W'(GAIN_INV);
			cy_in = '0;
			cz_in = Z_W'(barrel_q) <<< (ANG_Q - FRAC_BITS);
		end else begin
			cx_in = XY_W'(ax) <<< VEC_PRESCALE;
			cy_in = XY_W'(ay) <<< VEC_PRESCALE;
			cz_in = '0;
		end
	end

	aavl_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (cctrl),
		.x_in  (cx_in),
		.y_in  (cy_in),
		.z_in  (cz_in),
		.x_out (cx),
		.y_out (cy),
		.z_out (cz),
		.stat  (cstat)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	assign mul_last = (mcnt_q == MCW'(SPD_W - 1));

	always_comb begin
		state_d  = state_q;
		mul_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_CORD;
			end
			ST_CORD: begin
				// shoot waits until the last micro-rotation has landed
				if (op_q == OP_SHOOT) begin
					if (!cstat.run) begin
						state_d  = ST_MUL;
						mul_load = 1'b1;
					end
				end else if (cstat.last) begin
					state_d = ST_FIN;
				end
			end
			ST_MUL: begin
				if (mul_last) state_d = ST_FIN;
			end
			ST_FIN:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// capture the item's flags and operands on the accepted beat
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= opcode;
			degen_q <= (dx == '0) && (dy == '0);
			vert_q  <= (dx == '0);
			horz_q  <= (dy == '0);
			dypos_q <= !dy[12] && (dy != '0);
		end
	end

	// shift-add multipliers, lsb first; cos/sin times speed and barrel length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mcnt_q <= '0;
		end else if (mul_load) begin
			mcnt_q <= '0;
		end else if (state_q == ST_MUL) begin
			mcnt_q <= mcnt_q + MCW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (mul_load) begin
			// cordic registers hold their final values by now
			mc_c_q   <= PW'(cx);
			mc_s_q   <= PW'(cy);
			mlen_q   <= len_q;
			acc_lc_q <= '0;
			acc_ls_q <= '0;
			acc_vc_q <= '0;
			acc_vs_q <= '0;
		end else if (state_q == ST_MUL) begin
			if (mspd_q[0]) begin
				acc_vc_q <= acc_vc_q + mc_c_q;
				acc_vs_q <= acc_vs_q + mc_s_q;
			end
			if (mlen_q[0]) begin
				acc_lc_q <= acc_lc_q + mc_c_q;
				acc_ls_q <= acc_ls_q + mc_s_q;
			end
			mc_c_q <= mc_c_q <<< 1;
			mc_s_q <= mc_s_q <<< 1;
			mspd_q <= mspd_q >> 1;
			mlen_q <= mlen_q >> 1;
		end
		if (accept) mspd_q <= speed;
	end

	// rounding, clamping and final sums
	always_comb begin
		zr = (cz + Z_W'(1 <<< (ANG_Q - FRAC_BITS - 1))) >>> (ANG_Q - FRAC_BITS);
		if (degen_q)                    ang_new = barrel_q;
		else if (vert_q)                ang_new = dypos_q ? 16'(ANGLE_LIM) : -16'(ANGLE_LIM);
		else if (horz_q)                ang_new = '0;
		else if (zr > Z_W'(ANGLE_LIM))  ang_new = 16'(ANGLE_LIM);
		else if (zr < -Z_W'(ANGLE_LIM)) ang_new = -16'(ANGLE_LIM);
		else                            ang_new = zr[15:0];

		lc_r = (acc_lc_q + (PW'(1) <<< (TRIG_Q - FRAC_BITS - 1))) >>> (TRIG_Q - FRAC_BITS);
		ls_r = (acc_ls_q + (PW'(1) <<< (TRIG_Q - FRAC_BITS - 1))) >>> (TRIG_Q - FRAC_BITS);
		vc_r = (acc_vc_q + (PW'(1) <<< (TRIG_Q - 1))) >>> TRIG_Q;
		vs_r = -((acc_vs_q + (PW'(1) <<< (TRIG_Q - 1))) >>> TRIG_Q);
		mx_f = ($signed({{(PW-12){1'b0}}, ox_q}) <<< FRAC_BITS) + lc_r;
		my_f = ($signed({{(PW-12){1'b0}}, oy_q}) <<< FRAC_BITS) - ls_r;

		if (vc_r > PW'(VEL_LIMIT))       vx_f = PW'(VEL_LIMIT);
		else if (vc_r < -PW'(VEL_LIMIT)) vx_f = -PW'(VEL_LIMIT);
		else                             vx_f = vc_r;
		if (vs_r > PW'(VEL_LIMIT))       vy_f = PW'(VEL_LIMIT);
		else if (vs_r < -PW'(VEL_LIMIT)) vy_f = -PW'(VEL_LIMIT);
		else                             vy_f = vs_r;
	end

	// stored barrel angle; aim updates it in the finishing cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			barrel_q <= 16'(ANGLE_RESET);
		end else if (state_q == ST_FIN && op_q == OP_AIM) begin
			barrel_q <= ang_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else         done_q <= (state_q == ST_FIN);
	end

	// result beat payload
	always_ff @(posedge clk) begin
		if (state_q == ST_FIN) begin
			if (op_q == OP_AIM) begin
				angle_q     <= ang_new;
				degen_out_q <= degen_q;
				mx_q        <= '0;
				my_q        <= '0;
				vx_q        <= '0;
				vy_q        <= '0;
			end else begin
				angle_q     <= barrel_q;
				degen_out_q <= 1'b0;
				mx_q        <= mx_f[21:0];
				my_q        <= my_f[21:0];
				vx_q        <= vx_f[16:0];
				vy_q        <= vy_f[16:0];
			end
		end
	end

	assign done       = done_q;
	assign angle_out  = angle_q;
	assign muzzle_x   = mx_q;
	assign muzzle_y   = my_q;
	assign vel_x      = vx_q;
	assign vel_y      = vy_q;
	assign degenerate = degen_out_q;

	// result beat only once the core has gone idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result beat while busy");

	// an accepted item keeps the core busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted item not held");

	// each result beat follows a cycle of work
	a_done_past: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result beat without work");

	// the multiplier only runs after a shoot cordic pass
	a_mul_shoot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> (op_q == OP_SHOOT)) else $error("multiply on aim");

endmodule
